@@ src/plid_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional list package
// Operation codes and sequencer states shared by the positional list design.
// ----------------------------------------------------------------------------
package plid_pkg;

    // Operation codes carried on the func field of a transaction.
    typedef enum logic [1:0] {
        F_READ   = 2'd0,
        F_INSERT = 2'd1,
        F_DELETE = 2'd2,
        F_CLEAR  = 2'd3
    } t_func;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_state;

    // Widths of the fixed fields.
    localparam int unsigned POS_W   = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 6;

endpackage

@@ src/positional_list_insert_delete_core.sv @@
// ----------------------------------------------------------------------------
// Positional list insert/delete core
// Ordered list of signed 32-bit values with read, insert, delete and clear by
// 1-based position, kept in a single-port-pair memory.
//
//   Channel   Handshake          Ports
//   -------   ----------------   ------------------------------------------
//   command   start, busy        i_func, i_position, i_value_in
//   result    o_done (strobe)    o_ok, o_value_out, o_count, o_is_empty
//
// A transaction is accepted when start is high and busy is low; busy stays
// high until the result strobe has been shown. A read fetches its entry in
// S_SHIFT and captures it in S_DRAIN; insert and delete shift the later
// entries in those states, one entry through the memory per cycle, limited
// by its single read and write ports, and insert then writes its value in
// S_PUT, going straight there to append after the last entry. Rejected
// operations and clear go straight to S_DONE. Reset empties the list at
// once; the memory needs no clearing. The result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core
    import plid_pkg::*;
#(
    parameter int unsigned DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_func,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [VALUE_W-1:0] i_value_in,
    output logic                      o_done,
    output logic                      o_ok,
    output logic signed [VALUE_W-1:0] o_value_out,
    output logic [COUNT_W-1:0]        o_count,
    output logic                      o_is_empty
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W  = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;

    // Control state.
    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_wpend, n_wpend;
    logic                r_cap, n_cap;
    logic                r_first, n_first;

    // Operation payload.
    t_func               r_op;
    logic [ADDR_W-1:0]   r_src, n_src;
    logic [ADDR_W-1:0]   r_end;
    logic [ADDR_W-1:0]   r_wa;
    logic [VALUE_W-1:0]  r_val;
    logic [VALUE_W-1:0]  r_vout;
    logic                r_ok;

    // Memory port signals.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [VALUE_W-1:0]  ram_rdata;

    // Decode of the incoming transaction.
    logic                accept;
    t_func               in_op;
    logic [CMP_W-1:0]    pos_x;
    logic [CMP_W-1:0]    fill_x;
    logic                pos_ok;
    logic                ins_ok;
    logic                ins_tail;
    logic [ADDR_W-1:0]   pos_m1;
    logic [ADDR_W-1:0]   fill_m1;

    assign accept   = start && (r_state == S_IDLE);
    assign in_op    = t_func'(i_func);
    assign pos_x    = CMP_W'(i_position);
    assign fill_x   = CMP_W'(r_fill);
    assign pos_ok   = (pos_x != '0) && (pos_x <= fill_x);
    assign ins_ok   = (fill_x < CMP_W'(DEPTH)) && (pos_x != '0)
                      && (pos_x <= fill_x + CMP_W'(1));
    assign ins_tail = (pos_x == fill_x + CMP_W'(1));
    assign pos_m1   = ADDR_W'(pos_x - CMP_W'(1));
    assign fill_m1  = ADDR_W'(fill_x - CMP_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        F_READ, F_DELETE: n_state = pos_ok ? S_SHIFT : S_DONE;
                        F_INSERT: begin
                            if (!ins_ok) begin
                                n_state = S_DONE;
                            end else if (ins_tail) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_src == r_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = (r_op == F_INSERT) ? S_PUT : S_DONE;
            S_PUT:   n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: memory port control and pipeline flags.
    always_comb begin
        n_src   = r_src;
        n_wpend = 1'b0;
        n_cap   = 1'b0;
        n_first = r_first;
        ram_re  = 1'b0;
        if (r_state == S_PUT) begin
            ram_we    = 1'b1;
            ram_waddr = r_end;
            ram_wdata = r_val;
        end else begin
            ram_we    = r_wpend;
            ram_waddr = r_wa;
            ram_wdata = ram_rdata;
        end
        case (r_state)
            S_SHIFT: begin
                ram_re  = 1'b1;
                n_first = 1'b0;
                n_cap   = r_first;
                n_wpend = (r_op != F_READ) && !r_first;
                if (r_op == F_INSERT) begin
                    n_src = r_src - ADDR_W'(1);
                end else begin
                    n_src = r_src + ADDR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Fill count after the accepted operation.
    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            case (in_op)
                F_INSERT: if (ins_ok) n_fill = r_fill + FILL_W'(1);
                F_DELETE: if (pos_ok) n_fill = r_fill - FILL_W'(1);
                F_CLEAR:  n_fill = '0;
                default:  n_fill = r_fill;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_wpend <= 1'b0;
            r_cap   <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_wpend <= n_wpend;
            r_cap   <= n_cap;
            r_first <= accept ? (in_op == F_READ || in_op == F_DELETE) : n_first;
        end
    end

    // Operation payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= in_op;
            r_val  <= i_value_in;
            r_vout <= '0;
            case (in_op)
                F_READ: begin
                    r_src <= pos_m1;
                    r_end <= pos_m1;
                    r_ok  <= pos_ok;
                end
                F_DELETE: begin
                    r_src <= pos_m1;
                    r_end <= fill_m1;
                    r_ok  <= pos_ok;
                end
                F_INSERT: begin
                    r_src <= fill_m1;
                    r_end <= pos_m1;
                    r_ok  <= ins_ok;
                end
                default: begin
                    r_ok <= 1'b1;
                end
            endcase
        end else begin
            r_src <= n_src;
            if (r_cap) begin
                r_vout <= ram_rdata;
            end
        end
        // Each read lands in the next cycle and is written one place over.
        if (r_state == S_SHIFT) begin
            r_wa <= (r_op == F_INSERT) ? (r_src + ADDR_W'(1)) : (r_src - ADDR_W'(1));
        end
    end

    // Entry store.
    plid_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (VALUE_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    // Result ports.
    assign busy        = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_ok        = r_ok;
    assign o_value_out = r_vout;
    assign o_count     = COUNT_W'(fill_x);
    assign o_is_empty  = (r_fill == '0);

    // The list never holds more entries than the store.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill) <= CMP_W'(DEPTH))
        else $error("fill count exceeds store depth");

    // An accepted transaction makes the core busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a transaction");

    // The result strobe lasts one cycle and releases the core.
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("core still busy after result strobe");

    // A rejected operation carries a zero value.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_value_out == '0))
        else $error("rejected operation returned a nonzero value");

endmodule

@@ src/plid_ram.sv @@
// ----------------------------------------------------------------------------
// Positional list entry store
// Single write port and single read port memory with registered read data.
// ----------------------------------------------------------------------------
module plid_ram #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned DATA_W = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
